@@ hdl/usd_pkg.sv @@
// usd_pkg: types, constants and lookup functions for the UTF-8 stream decoder.
// Used by every module of the decoder; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package usd_pkg;

  localparam int COUNT_BITS_DEF  = 20;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CODE_BITS        = 21;
  localparam int COUNT_FIELD_BITS = 20;
  localparam int STATE_BITS       = 4;
  localparam int CLASS_BITS       = 4;
  localparam int NUM_STATES       = 9;
  localparam int NUM_CLASSES      = 12;

  localparam logic [COUNT_FIELD_BITS-1:0] COUNT_FIELD_MAX = '1;

  localparam logic [STATE_BITS-1:0] ST_ACCEPT = 4'd0;
  localparam logic [STATE_BITS-1:0] ST_REJECT = 4'd1;
  localparam logic [STATE_BITS-1:0] ST_LAST   = 4'd8;

  localparam logic [1:0] STATUS_CODE_POINT = 2'd0;
  localparam logic [1:0] STATUS_INVALID    = 2'd1;
  localparam logic [1:0] STATUS_TRUNCATED  = 2'd2;

  typedef struct packed {
    logic [CLASS_BITS-1:0] cls;
    logic [7:0]            data;
    logic                  last;
  } usd_item_t;

  typedef struct packed {
    logic [CODE_BITS-1:0]        code_point;
    logic [1:0]                  status;
    logic                        end_of_string;
    logic [COUNT_FIELD_BITS-1:0] count;
  } usd_result_t;

  localparam logic [STATE_BITS-1:0] NEXT_STATE_TBL [NUM_STATES][NUM_CLASSES] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
  };

  function automatic logic [CLASS_BITS-1:0] byte_class_f(input logic [7:0] b);
    logic [CLASS_BITS-1:0] c;
    case (b) inside
      [8'h00:8'h7F]: c = 4'd0;
      [8'h80:8'h8F]: c = 4'd1;
      [8'h90:8'h9F]: c = 4'd9;
      [8'hA0:8'hBF]: c = 4'd7;
      [8'hC0:8'hC1]: c = 4'd8;
      [8'hC2:8'hDF]: c = 4'd2;
      8'hE0:         c = 4'd10;
      8'hED:         c = 4'd4;
      [8'hE1:8'hEF]: c = 4'd3;
      8'hF0:         c = 4'd11;
      [8'hF1:8'hF3]: c = 4'd6;
      8'hF4:         c = 4'd5;
      default:       c = 4'd8;
    endcase
    return c;
  endfunction

  // Out-of-range state or class falls to reject.
  function automatic logic [STATE_BITS-1:0] next_state_f(input logic [STATE_BITS-1:0] st,
                                                         input logic [CLASS_BITS-1:0] cls);
    logic [STATE_BITS-1:0] n;
    if (st > ST_LAST || cls > CLASS_BITS'(NUM_CLASSES - 1)) begin
      n = ST_REJECT;
    end else begin
      n = NEXT_STATE_TBL[st][cls];
    end
    return n;
  endfunction

endpackage

`default_nettype wire

@@ hdl/usd_classifier.sv @@
// usd_classifier: front stage; accepts raw bytes, tags each with its character class.
// Depends on usd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module usd_classifier (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_last_byte,
  input  wire logic              in_push,
  output logic                   in_full,
  output usd_pkg::usd_item_t     q_item,
  output logic                   q_push,
  input  wire logic              q_full
);
  import usd_pkg::*;

  logic      valid_r, valid_nxt;
  usd_item_t item_r;
  logic      load;

  assign in_full   = valid_r && q_full;
  assign load      = in_push && !in_full;
  assign valid_nxt = load || (valid_r && q_full);
  assign q_push    = valid_r && !q_full;
  assign q_item    = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.cls  <= byte_class_f(in_data_byte);
      item_r.data <= in_data_byte;
      item_r.last <= in_last_byte;
    end
  end

endmodule

`default_nettype wire

@@ hdl/usd_fifo.sv @@
// usd_fifo: short show-ahead queue of classified bytes between front and back.
// Depends on usd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module usd_fifo #(
  parameter int DEPTH = usd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  usd_pkg::usd_item_t push_item,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output usd_pkg::usd_item_t head_item
);
  import usd_pkg::*;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  usd_item_t           mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full      = (cnt_r == CNT_BITS'(DEPTH));
  assign empty     = (cnt_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ hdl/usd_engine.sv @@
// usd_engine: back stage; runs the UTF-8 automaton, builds code points, keeps the
// running count and holds the result register. Depends on usd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module usd_engine #(
  parameter int COUNT_BITS = usd_pkg::COUNT_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  usd_pkg::usd_item_t q_item,
  input  wire logic          q_empty,
  output logic               q_pop,
  output usd_pkg::usd_result_t res,
  output logic               res_valid,
  input  wire logic          res_pop
);
  import usd_pkg::*;

  logic [STATE_BITS-1:0] state_r, state_nxt, st_eff, st_new;
  logic [CODE_BITS-1:0]  partial_r, partial_nxt, partial_new;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic                  out_valid_r, out_valid_nxt;
  usd_result_t           out_r, out_new;
  logic                  take, emit, completed;
  logic [COUNT_FIELD_BITS-1:0] cnt_inc_field, cnt_field;

  assign take    = !q_empty && (!out_valid_r || res_pop);
  assign q_pop   = take;
  assign cnt_inc = (cnt_r == '1) ? cnt_r : cnt_r + COUNT_BITS'(1);

  generate
    if (COUNT_BITS > COUNT_FIELD_BITS) begin : g_sat
      assign cnt_inc_field = (cnt_inc > COUNT_BITS'(COUNT_FIELD_MAX)) ?
                             COUNT_FIELD_MAX : cnt_inc[COUNT_FIELD_BITS-1:0];
      assign cnt_field     = (cnt_r > COUNT_BITS'(COUNT_FIELD_MAX)) ?
                             COUNT_FIELD_MAX : cnt_r[COUNT_FIELD_BITS-1:0];
    end else begin : g_ext
      assign cnt_inc_field = COUNT_FIELD_BITS'(cnt_inc);
      assign cnt_field     = COUNT_FIELD_BITS'(cnt_r);
    end
  endgenerate

  always_comb begin
    st_eff      = (state_r > ST_LAST) ? ST_REJECT : state_r;
    partial_new = partial_r;
    st_new      = ST_REJECT;
    completed   = 1'b0;
    emit        = 1'b0;
    out_new.code_point    = '0;
    out_new.status        = STATUS_INVALID;
    out_new.end_of_string = 1'b1;
    out_new.count         = cnt_field;
    if (st_eff != ST_REJECT) begin
      if (st_eff != ST_ACCEPT) begin
        partial_new = {partial_r[CODE_BITS-7:0], q_item.data[5:0]};
      end else begin
        partial_new = CODE_BITS'((8'hFF >> q_item.cls) & q_item.data);
      end
      st_new = next_state_f(st_eff, q_item.cls);
      if (st_new == ST_ACCEPT) begin
        completed             = 1'b1;
        emit                  = 1'b1;
        out_new.code_point    = partial_new;
        out_new.status        = STATUS_CODE_POINT;
        out_new.end_of_string = q_item.last;
        out_new.count         = cnt_inc_field;
      end else if (q_item.last) begin
        emit           = 1'b1;
        out_new.status = (st_new == ST_REJECT) ? STATUS_INVALID : STATUS_TRUNCATED;
      end
    end else begin
      emit = q_item.last;
    end

    state_nxt   = state_r;
    partial_nxt = partial_r;
    cnt_nxt     = cnt_r;
    if (take) begin
      if (q_item.last) begin
        state_nxt   = ST_ACCEPT;
        partial_nxt = '0;
        cnt_nxt     = '0;
      end else begin
        state_nxt   = st_new;
        partial_nxt = partial_new;
        cnt_nxt     = completed ? cnt_inc : cnt_r;
      end
    end

    out_valid_nxt = take ? emit : (out_valid_r && !res_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCEPT;
      partial_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      partial_r   <= partial_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_r <= out_new;
    end
  end

  assign res       = out_r;
  assign res_valid = out_valid_r;

  a_err_ends_string: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != STATUS_CODE_POINT |-> out_r.end_of_string)
    else $error("error status on a result that does not end the string");

  a_err_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != STATUS_CODE_POINT |-> out_r.code_point == '0)
    else $error("error status with nonzero code point");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && q_item.last |=> state_r == ST_ACCEPT && cnt_r == '0 && partial_r == '0)
    else $error("state not cleared after last byte");

  a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r <= ST_LAST)
    else $error("automaton state out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_pop |-> !take)
    else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ hdl/utf8_stream_decoder.sv @@
// utf8_stream_decoder: top level; classifier front, queue, automaton back end.
// Depends on usd_pkg, usd_classifier, usd_fifo, usd_engine.
`timescale 1ns / 1ps
`default_nettype none

// One byte per push, last_byte marking the final byte of a string. Sustained
// rate is one byte per cycle while pop keeps up: the classifier register, the
// queue and the automaton each take a byte every cycle. Each byte passes the
// classifier register and a queue entry, and its result is registered. Bytes
// that finish no code point give no result; the last byte always gives one,
// and a nonzero status tells the consumer to discard the code points already
// delivered for that string. Backpressure on pop fills the queue (QUEUE_DEPTH
// entries plus the classifier and result registers) before full rises.
module utf8_stream_decoder #(
  parameter int COUNT_BITS  = usd_pkg::COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = usd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  input  wire logic        push,
  output logic             full,
  output logic [20:0]      out_code_point,
  output logic [1:0]       out_status,
  output logic             out_end_of_string,
  output logic [19:0]      out_count,
  output logic             empty,
  input  wire logic        pop
);
  import usd_pkg::*;

  usd_item_t   cls_item, head_item;
  logic        q_push, q_full, q_pop, q_empty;
  usd_result_t res;
  logic        res_valid;

  usd_classifier u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .in_push      (push),
    .in_full      (full),
    .q_item       (cls_item),
    .q_push       (q_push),
    .q_full       (q_full)
  );

  usd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (cls_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_item (head_item)
  );

  usd_engine #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_item    (head_item),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .res       (res),
    .res_valid (res_valid),
    .res_pop   (pop)
  );

  assign out_code_point    = res.code_point;
  assign out_status        = res.status;
  assign out_end_of_string = res.end_of_string;
  assign out_count         = res.count;
  assign empty             = !res_valid;

endmodule

`default_nettype wire
